/* design/c_token_scanner_defines.svh */
// Assertion macros shared by the token scanner RTL.
`ifndef C_TOKEN_SCANNER_DEFINES_SVH
`define C_TOKEN_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define CTS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("token scanner check failed");

// Same-cycle implication.
`define CTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("token scanner check failed");

// Next-cycle implication.
`define CTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("token scanner check failed");

`else

`define CTS_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define CTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* design/cts_pkg.sv */
// Types, codes and byte-class decoders for the token scanner.
`default_nettype none

package cts_pkg;

    localparam int NUM_KW      = 20;
    localparam int KW_IDX_W    = 5;
    localparam int TOKEN_LEN_W = 7;

    // Token length saturates here; must fit in TOKEN_LEN_W bits.
    localparam int MAX_LEN     = 64;

    localparam logic [2:0] CLS_KEYWORD    = 3'd0;
    localparam logic [2:0] CLS_IDENTIFIER = 3'd1;
    localparam logic [2:0] CLS_CONSTANT   = 3'd2;
    localparam logic [2:0] CLS_OPERATOR   = 3'd3;
    localparam logic [2:0] CLS_SPECIAL    = 3'd4;
    localparam logic [2:0] CLS_UNKNOWN    = 3'd5;

    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Keyword text right-justified: last character in the low byte.
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("int"), 64'("float"), 64'("return"), 64'("if"), 64'("else"),
        64'("while"), 64'("for"), 64'("do"), 64'("break"), 64'("continue"),
        64'("char"), 64'("double"), 64'("void"), 64'("switch"), 64'("case"),
        64'("default"), 64'("const"), 64'("static"), 64'("sizeof"),
        64'("struct")
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd5, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd5, 4'd8,
        4'd4, 4'd6, 4'd4, 4'd6, 4'd4, 4'd7, 4'd5, 4'd6, 4'd6, 4'd6
    };

    typedef struct packed {
        logic                   last;
        logic                   too_long;
        logic [7:0]             first_char;
        logic [TOKEN_LEN_W-1:0] token_length;
        logic [KW_IDX_W-1:0]    keyword_index;
        logic [2:0]             token_class;
    } result_t;

    // Byte at position pos of keyword k; only meaningful for pos < length.
    function automatic logic [7:0] kw_byte(input logic [63:0] text,
                                           input logic [3:0] len,
                                           input logic [2:0] pos);
        logic [2:0] sh;
        sh = 3'(len - 4'd1 - {1'b0, pos});
        return text[{sh, 3'b000} +: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic logic [2:0] punct_class(input logic [7:0] c);
        logic [2:0] cls;
        unique case (c) inside
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h21, 8'h3C, 8'h3E,
            8'h7C, 8'h26:
                cls = CLS_OPERATOR;
            8'h2C, 8'h3B, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h23:
                cls = CLS_SPECIAL;
            default:
                cls = CLS_IDENTIFIER;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

/* design/c_token_scanner.sv */
// Byte-serial token scanner for C-like source text.
//
// Input channel: one source byte per beat on s_tdata; s_tlast marks end of
// text, flushes a pending token and returns the scanner to idle (the byte
// in that beat is ignored). Result channel: one token per beat on m_tdata;
// m_tlast flags the final token caused by one input beat (a word cut by
// punctuation gives two tokens from one beat).
// An accepted byte is registered in the input stage and decoded from there;
// its tokens are written to the output queue, which presents its head.
// Throughput: one byte per cycle while the output queue has room. The decode
// stage writes up to two tokens per cycle into a four-entry output queue; it
// holds while the queue has fewer than two free entries, so a stalled
// receiver stops s_tready and nothing is lost. When two tokens come from
// every byte, the output port limits the rate to one token per cycle.
// Reset (aresetn low, synchronous) empties the queue and the input stage
// and clears the pending token.
`default_nettype none

`include "c_token_scanner_defines.svh"

module c_token_scanner
    import cts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] token_class, [7:3] keyword_index,
                                        // [14:8] token_length, [22:15] first_char,
                                        // [23] too_long
    output logic             m_tlast    // last
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       eot_reg;

    // Token state
    logic              in_word_reg, in_word_next;
    logic              in_string_reg, in_string_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              all_digits_reg, all_digits_next;
    logic [NUM_KW-1:0] kw_alive_reg, kw_alive_next;
    logic [7:0]        start_byte_reg, start_byte_next;
    logic              overflow_reg, overflow_next;

    // Output queue
    result_t              q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_after_pop;

    logic       pop;
    logic       fire;
    logic [1:0] res_n;
    result_t    res0, res1;
    result_t    word_res;
    result_t    q_head;

    logic              kw_hit;
    logic [KW_IDX_W-1:0] kw_idx;
    logic [LEN_W-1:0]  len_inc;
    logic              ovf_inc;

    assign pop             = m_tvalid && m_tready;
    assign count_after_pop = count_reg - Q_CNT_W'(pop);
    assign fire            = in_valid_reg && (count_after_pop <= Q_CNT_W'(2));
    assign s_tready        = !in_valid_reg || fire;

    assign q_head   = q_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {q_head.too_long, q_head.first_char, q_head.token_length,
                       q_head.keyword_index, q_head.token_class};
    assign m_tlast  = q_head.last;

    // Saturating length for one more byte
    always_comb begin
        if (length_reg < LEN_W'(MAX_LEN)) begin
            len_inc = length_reg + LEN_W'(1);
            ovf_inc = overflow_reg;
        end else begin
            len_inc = length_reg;
            ovf_inc = 1'b1;
        end
    end

    // Word classification from the match bits
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (kw_alive_reg[k] && (length_reg == LEN_W'(KW_LEN[k]))) begin
                kw_hit = 1'b1;
                kw_idx = KW_IDX_W'(k);
            end
        end
        if (overflow_reg) begin
            kw_hit = 1'b0;
        end
        word_res               = '0;
        word_res.token_length  = TOKEN_LEN_W'(length_reg);
        word_res.first_char    = start_byte_reg;
        if (kw_hit) begin
            word_res.token_class   = CLS_KEYWORD;
            word_res.keyword_index = kw_idx;
        end else begin
            word_res.token_class = all_digits_reg ? CLS_CONSTANT : CLS_IDENTIFIER;
            word_res.too_long    = overflow_reg;
        end
    end

    // Per-byte decode
    always_comb begin
        in_word_next    = in_word_reg;
        in_string_next  = in_string_reg;
        length_next     = length_reg;
        all_digits_next = all_digits_reg;
        kw_alive_next   = kw_alive_reg;
        start_byte_next = start_byte_reg;
        overflow_next   = overflow_reg;
        res_n           = 2'd0;
        res0            = '0;
        res1            = '0;

        if (eot_reg) begin
            if (in_word_reg) begin
                res0  = word_res;
                res_n = 2'd1;
            end else if (in_string_reg) begin
                res0.token_class  = CLS_UNKNOWN;
                res0.token_length = TOKEN_LEN_W'(length_reg);
                res0.first_char   = CH_QUOTE;
                res0.too_long     = overflow_reg;
                res_n             = 2'd1;
            end
            in_word_next    = 1'b0;
            in_string_next  = 1'b0;
            length_next     = '0;
            all_digits_next = 1'b1;
            kw_alive_next   = '1;
            start_byte_next = '0;
            overflow_next   = 1'b0;
        end else if (in_string_reg) begin
            if (ch_reg == CH_QUOTE) begin
                res0.token_class  = CLS_CONSTANT;
                res0.token_length = TOKEN_LEN_W'(len_inc);
                res0.first_char   = CH_QUOTE;
                res0.too_long     = ovf_inc;
                res_n             = 2'd1;
                in_string_next    = 1'b0;
                length_next       = '0;
                start_byte_next   = '0;
                overflow_next     = 1'b0;
            end else begin
                length_next   = len_inc;
                overflow_next = ovf_inc;
            end
        end else if (is_space(ch_reg)) begin
            if (in_word_reg) begin
                res0            = word_res;
                res_n           = 2'd1;
                in_word_next    = 1'b0;
                length_next     = '0;
                all_digits_next = 1'b1;
                kw_alive_next   = '1;
                start_byte_next = '0;
                overflow_next   = 1'b0;
            end
        end else if (is_punct(ch_reg)) begin
            in_word_next    = 1'b0;
            length_next     = '0;
            all_digits_next = 1'b1;
            kw_alive_next   = '1;
            start_byte_next = '0;
            overflow_next   = 1'b0;
            if (in_word_reg) begin
                res0  = word_res;
                res_n = 2'd1;
            end
            if (ch_reg == CH_QUOTE) begin
                in_string_next  = 1'b1;
                start_byte_next = CH_QUOTE;
                length_next     = LEN_W'(1);
            end else if (in_word_reg) begin
                res1.token_class  = punct_class(ch_reg);
                res1.token_length = TOKEN_LEN_W'(1);
                res1.first_char   = ch_reg;
                res_n             = 2'd2;
            end else begin
                res0.token_class  = punct_class(ch_reg);
                res0.token_length = TOKEN_LEN_W'(1);
                res0.first_char   = ch_reg;
                res_n             = 2'd1;
            end
        end else begin
            // word byte: narrow the keyword candidates by position
            in_word_next = 1'b1;
            if (!in_word_reg) begin
                start_byte_next = ch_reg;
            end
            for (int k = 0; k < NUM_KW; k++) begin
                if (!((length_reg < LEN_W'(KW_LEN[k])) &&
                      (kw_byte(KW_TEXT[k], KW_LEN[k], length_reg[2:0]) == ch_reg))) begin
                    kw_alive_next[k] = 1'b0;
                end
            end
            if (ch_reg < 8'h30 || ch_reg > 8'h39) begin
                all_digits_next = 1'b0;
            end
            length_next   = len_inc;
            overflow_next = ovf_inc;
        end

        res0.last = (res_n == 2'd1);
        res1.last = 1'b1;
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            ch_reg  <= s_tdata;
            eot_reg <= s_tlast;
        end
    end

    // Token state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg    <= 1'b0;
            in_string_reg  <= 1'b0;
            length_reg     <= '0;
            all_digits_reg <= 1'b1;
            kw_alive_reg   <= '1;
            start_byte_reg <= '0;
            overflow_reg   <= 1'b0;
        end else if (fire) begin
            in_word_reg    <= in_word_next;
            in_string_reg  <= in_string_next;
            length_reg     <= length_next;
            all_digits_reg <= all_digits_next;
            kw_alive_reg   <= kw_alive_next;
            start_byte_reg <= start_byte_next;
            overflow_reg   <= overflow_next;
        end
    end

    // Output queue storage
    always_ff @(posedge aclk) begin
        if (fire && res_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (fire && res_n == 2'd2) begin
            q_mem[wr_ptr_reg + Q_PTR_W'(1)] <= res1;
        end
    end

    // Output queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (fire) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(res_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_after_pop + (fire ? Q_CNT_W'(res_n) : Q_CNT_W'(0));
        end
    end

    `CTS_ASSERT_ALWAYS(a_queue_bound, aclk, aresetn, count_reg <= Q_CNT_W'(Q_DEPTH))
    `CTS_ASSERT_ALWAYS(a_word_xor_string, aclk, aresetn, !(in_word_reg && in_string_reg))
    `CTS_ASSERT_IMPL(a_idle_len_zero, aclk, aresetn, !in_word_reg && !in_string_reg,
        length_reg == '0)
    `CTS_ASSERT_IMPL(a_ovf_saturated, aclk, aresetn, overflow_reg,
        length_reg == LEN_W'(MAX_LEN))
    `CTS_ASSERT_NEXT(a_result_shown, aclk, aresetn, fire && res_n != 2'd0, m_tvalid)

endmodule

`default_nettype wire
